[rtl/lru_pkg.sv]
// Package: geometry constants and shared types for the age-counter LRU block.
`timescale 1ns / 1ps
package lru_pkg;

  localparam int WAYS   = 8;
  localparam int SETS   = 64;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AGE_W  = $clog2(WAYS);
  localparam int ADDR_W = 64;
  localparam int IDX_W  = SET_W + WAY_W;
  localparam int META_W = WAYS + WAYS * AGE_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  typedef enum logic {
    KIND_HIT  = 1'b0,
    KIND_FILL = 1'b1
  } kind_t;

  typedef struct packed {
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            valid;
  } meta_t;

  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic             was_valid;
    meta_t            meta;
  } upd_t;

endpackage

[rtl/lru_mem.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module lru_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/lru_age_unit.sv]
// Victim selection and age update for one set.
`timescale 1ns / 1ps
module lru_age_unit (
  input  logic                 kind,
  input  logic [lru_pkg::WAY_W-1:0] hit_way,
  input  lru_pkg::meta_t       meta_in,
  output lru_pkg::upd_t        upd
);
  import lru_pkg::*;

  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] w;
  logic             found;
  logic [AGE_W-1:0] best_age;
  logic [AGE_W-1:0] old_age;
  logic             wv;
  meta_t            m;

  always_comb begin
    victim   = '0;
    found    = 1'b0;
    best_age = meta_in.age[0];
    for (int i = 0; i < WAYS; i++) begin
      if (!found && !meta_in.valid[i]) begin
        victim = WAY_W'(i);
        found  = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 1; i < WAYS; i++) begin
        if (meta_in.age[i] > best_age) begin
          best_age = meta_in.age[i];
          victim   = WAY_W'(i);
        end
      end
    end
  end

  assign w       = (kind == KIND_FILL) ? victim : hit_way;
  assign old_age = meta_in.age[w];
  assign wv      = meta_in.valid[w];

  always_comb begin
    m = meta_in;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == w) begin
        m.age[i] = '0;
      end else if (meta_in.valid[i] && (!wv || meta_in.age[i] <= old_age) &&
                   meta_in.age[i] != AGE_MAX) begin
        m.age[i] = meta_in.age[i] + AGE_W'(1);
      end
    end
    if (kind == KIND_FILL) begin
      m.valid[w] = 1'b1;
    end
  end

  assign upd.way       = w;
  assign upd.was_valid = wv;
  assign upd.meta      = m;

endmodule

[rtl/lru_replacement_policy.sv]
// Top level: age-counter LRU replacement with per-set metadata and line address RAMs.
// Path: accept reads the metadata RAM, ST_UPD writes it back and reads the line address RAM,
// ST_OUT loads the output register once free. One request at a time: metadata RMW.
// A new request is taken while a finished result still waits in the output register.
// Reset: synchronous active-low; per-set init flags make all ages and valid bits read as zero,
// has_lower_level resets to 1. Line address RAM contents are undefined until written.
`timescale 1ns / 1ps
module lru_replacement_policy (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,   // has_lower_level
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_tuser,      // kind
  // set_index[5:0], way[8:6], line_addr[72:9], zero pad
  input  logic [lru_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // chosen_way[2:0], evict_valid[3], evict_addr[67:4], zero pad
  output logic [lru_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lru_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_UPD  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                  hll_r;
  logic [SETS-1:0]       init_r;
  logic                  kind_r;
  logic [SET_W-1:0]      set_r;
  logic [WAY_W-1:0]      way_r;
  logic [ADDR_W-1:0]     laddr_r;
  logic [WAY_W-1:0]      chosen_r;
  logic                  ev_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  in_fire;
  logic                  out_free;
  logic [SET_W-1:0]      in_set;
  logic [META_W-1:0]     meta_rdata;
  meta_t                 meta_cur;
  upd_t                  upd;
  logic [ADDR_W-1:0]     addr_rdata;
  logic [IDX_W-1:0]      addr_idx;
  logic                  upd_st;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_set    = in_tdata[SET_W-1:0];
  assign upd_st    = (state_r == ST_UPD);

  lru_mem #(.DEPTH(SETS), .WIDTH(META_W)) u_meta_mem (
    .clk     (clk),
    .wr_en   (upd_st),
    .wr_addr (set_r),
    .wr_data (upd.meta),
    .rd_en   (in_fire),
    .rd_addr (in_set),
    .rd_data (meta_rdata)
  );

  assign meta_cur = init_r[set_r] ? meta_t'(meta_rdata) : '0;

  lru_age_unit u_age (
    .kind    (kind_r),
    .hit_way (way_r),
    .meta_in (meta_cur),
    .upd     (upd)
  );

  assign addr_idx = {set_r, upd.way};

  lru_mem #(.DEPTH(SETS * WAYS), .WIDTH(ADDR_W)) u_addr_mem (
    .clk     (clk),
    .wr_en   (upd_st && kind_r == KIND_FILL),
    .wr_addr (addr_idx),
    .wr_data (laddr_r),
    .rd_en   (upd_st),
    .rd_addr (addr_idx),
    .rd_data (addr_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hll_r       <= 1'b1;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        hll_r <= cfg_wr_data;
      end
      if (upd_st) begin
        init_r[set_r] <= 1'b1;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_tuser;
      set_r   <= in_set;
      way_r   <= in_tdata[SET_W +: WAY_W];
      laddr_r <= in_tdata[9 +: ADDR_W];
    end
    if (upd_st) begin
      chosen_r <= upd.way;
      ev_r     <= (kind_r == KIND_FILL) && hll_r && upd.was_valid;
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r <= {4'b0, (ev_r ? addr_rdata : {ADDR_W{1'b0}}), ev_r, chosen_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[verif/lru_replacement_checker.sv]
// Checker: watches request and result streams, predicts LRU results and compares them.
`timescale 1ns / 1ps
module lru_replacement_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic                           in_tuser,
  input  logic [lru_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [lru_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             outstanding
);
  import lru_pkg::*;

  typedef struct packed {
    logic [WAY_W-1:0]  way;
    logic              evict_valid;
    logic [ADDR_W-1:0] evict_addr;
  } lru_result_t;

  logic              line_valid [SETS][WAYS];
  logic [AGE_W-1:0]  line_age   [SETS][WAYS];
  logic [ADDR_W-1:0] line_addr  [SETS][WAYS];
  logic              lower_level;
  lru_result_t       pending_results [$];

  function automatic void promote_way(int s, int w);
    logic [AGE_W-1:0] old_age;
    logic             was_valid;
    old_age   = line_age[s][w];
    was_valid = line_valid[s][w];
    for (int i = 0; i < WAYS; i++) begin
      if (i != w && line_valid[s][i] && (!was_valid || line_age[s][i] <= old_age) &&
          line_age[s][i] < AGE_MAX)
        line_age[s][i] = line_age[s][i] + 1'b1;
    end
    line_age[s][w] = '0;
  endfunction

  function automatic int victim_way(int s);
    int best;
    for (int i = 0; i < WAYS; i++)
      if (!line_valid[s][i]) return i;
    best = 0;
    for (int i = 1; i < WAYS; i++)
      if (line_age[s][i] > line_age[s][best]) best = i;
    return best;
  endfunction

  function automatic lru_result_t predict_access(kind_t kind, logic [SET_W-1:0] set_field,
                                                 logic [WAY_W-1:0] way,
                                                 logic [ADDR_W-1:0] addr);
    lru_result_t r;
    int          s;
    int          w;
    r = '0;
    s = int'(set_field) % SETS;
    if (kind == KIND_HIT) begin
      r.way = way;
      if (int'(way) < WAYS) promote_way(s, int'(way));
    end else begin
      w     = victim_way(s);
      r.way = WAY_W'(w);
      promote_way(s, w);
      if (lower_level && line_valid[s][w]) begin
        r.evict_valid = 1'b1;
        r.evict_addr  = line_addr[s][w];
      end
      line_addr[s][w]  = addr;
      line_valid[s][w] = 1'b1;
    end
    return r;
  endfunction

  task automatic report_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    if (!rst_n) begin
      foreach (line_valid[s, w]) begin
        line_valid[s][w] = 1'b0;
        line_age[s][w]   = '0;
        line_addr[s][w]  = '0;
      end
      lower_level = 1'b1;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.way         = out_tdata[WAY_W-1:0];
        got.evict_valid = out_tdata[WAY_W];
        got.evict_addr  = out_tdata[WAY_W+1 +: ADDR_W];
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected result: way %0d evict %0b addr %h",
                                   got.way, got.evict_valid, got.evict_addr));
        end else begin
          want = pending_results.pop_front();
          if (got.way !== want.way || got.evict_valid !== want.evict_valid ||
              got.evict_addr !== want.evict_addr)
            report_failure($sformatf(
              "result mismatch: expected way %0d evict %0b addr %h, got way %0d evict %0b addr %h",
              want.way, want.evict_valid, want.evict_addr,
              got.way, got.evict_valid, got.evict_addr));
        end
      end
      if (cfg_wr_en) lower_level = cfg_wr_data;
      if (in_tvalid && in_tready)
        pending_results.push_back(predict_access(kind_t'(in_tuser), in_tdata[SET_W-1:0],
                                                 in_tdata[SET_W +: WAY_W],
                                                 in_tdata[SET_W+WAY_W +: ADDR_W]));
    end
    outstanding = pending_results.size();
  end

endmodule

[verif/lru_replacement_policy_tb.sv]
// Testbench top: drives requests, config writes and backpressure into the LRU block.
`timescale 1ns / 1ps
module lru_replacement_policy_tb;
  import lru_pkg::*;

  localparam int PHASE_REQUESTS = 458;
  localparam int HOT_SETS       = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic                  cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic                  in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count;
  int                    outstanding;
  bit                    stall_en;
  int                    stall_left;

  lru_replacement_policy DUT (.*);

  lru_replacement_checker lru_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result backpressure
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(kind_t kind, int set_index, int way, logic [ADDR_W-1:0] addr);
    int gap;
    if (stall_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_DATA_W'({addr, WAY_W'(way), SET_W'(set_index)});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_lower_level(bit value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random_phase(int count);
    logic [ADDR_W-1:0] addr;
    int                set_index;
    int                hot_set [HOT_SETS];
    foreach (hot_set[i]) hot_set[i] = $urandom_range(0, SETS - 1);
    repeat (count) begin
      addr = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) set_index = hot_set[$urandom_range(0, HOT_SETS - 1)];
      else set_index = $urandom_range(0, SETS - 1);
      send_request($urandom_range(0, 1) ? KIND_FILL : KIND_HIT, set_index,
                   $urandom_range(0, WAYS - 1), addr);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    stall_en    = 1'b1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    write_lower_level(1'b1);
    // hit on an empty set
    send_request(KIND_HIT, 0, 0, '0);
    for (int i = 0; i < WAYS - 1; i++)
      send_request(KIND_FILL, 9, i, (i == 0) ? '0 : (i == 1) ? '1 : {$urandom, $urandom});
    // hits on the one invalid way raise the age of every valid way, saturating the oldest
    repeat (3) send_request(KIND_HIT, 9, WAYS - 1, '0);
    send_request(KIND_FILL, 9, 0, 64'hA5A5_A5A5_A5A5_A5A5);
    // full set with tied ages: lowest index wins
    send_request(KIND_FILL, 9, 0, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(KIND_HIT, 9, 2, '1);
    send_request(KIND_HIT, 9, 2, '0);
    send_request(KIND_FILL, SETS - 1, WAYS - 1, '1);
    send_request(KIND_HIT, SETS - 1, WAYS - 1, '1);
    write_lower_level(1'b0);
    send_request(KIND_FILL, 9, 0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      write_lower_level(phase % 2 == 0);
      if (phase == 3) stall_en = 1'b0;
      run_random_phase(PHASE_REQUESTS);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
